[src/ospc_pkg.sv]
package ospc_pkg;

   // default sizes
   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int MAX_SAMPLES_DEF   = 16;
   localparam int AVERAGE_COUNT_DEF = 3;
   localparam int SKIP_OLDEST_DEF   = 1;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_WINDOW    = 2'd1;
   localparam logic [1:0] REG_CAPACITY  = 2'd2;

   localparam logic [19:0] THRESHOLD_RST = 20'd2000;
   localparam logic [3:0]  WINDOW_RST    = 4'd5;
   localparam logic [6:0]  CAPACITY_RST  = 7'd64;

   // result status codes
   localparam logic [1:0] STATUS_UPDATED  = 2'd0;
   localparam logic [1:0] STATUS_INSERTED = 2'd1;
   localparam logic [1:0] STATUS_REPEAT   = 2'd2;
   localparam logic [1:0] STATUS_FULL     = 2'd3;

   // speed arithmetic
   localparam logic [19:0] SPEED_MAX     = 20'hFFFFF;
   localparam int          SCALE_W       = 40;
   localparam logic [63:0] TIME_SCALE_SQ = 64'd1000000000000;

   // eviction and window limits
   localparam logic [2:0] STALE_LOW   = 3'd5;
   localparam logic [2:0] STALE_HIGH  = 3'd2;
   localparam int         MIN_RECORDS = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EVICT,
      ST_INSERT,
      ST_CHECK,
      ST_SUM,
      ST_SPEED_GO,
      ST_SPEED,
      ST_RESULT
   } ctrl_state_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SQX,
      PH_SQY,
      PH_SCALE,
      PH_SQRT,
      PH_DIV,
      PH_DONE
   } speed_phase_type;

   typedef struct packed {
      logic       capture;
      logic       sweep_clear;
      logic       sweep;
      logic       evict_mode;
      logic       insert;
      logic       append;
      logic       sum;
      logic       speed_start;
      logic       eval;
      logic       publish;
      logic [1:0] code;
   } ctrl_cmd_type;

   typedef struct packed {
      logic match;
      logic sweep_last;
      logic evict_needed;
      logic free_found;
      logic same_frame;
      logic enough;
      logic sum_last;
      logic speed_done;
      logic out_free;
   } dp_sts_type;

endpackage

[src/ospc_speed.sv]
module ospc_speed #(
   parameter int PW = 35,
   parameter int TW = 51,
   parameter int RW = 56
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [PW-1:0] sx,
   input  logic [PW-1:0] sy,
   input  logic [TW-1:0] st,
   output logic          done,
   output logic [RW-1:0] speed
);

   localparam int SW  = ospc_pkg::SCALE_W;
   localparam int MWE = 2 * RW;
   localparam int BW  = (PW > SW) ? PW : SW;
   localparam int NMX = (BW > RW) ? BW : RW;
   localparam int NW  = $clog2(NMX + 1);

   ospc_pkg::speed_phase_type phase_ff, phase_in;
   logic [MWE-1:0] acc_ff, acc_in;
   logic [MWE-1:0] mcand_ff, mcand_in;
   logic [BW-1:0]  mplier_ff, mplier_in;
   logic [NW-1:0]  cnt_ff, cnt_in;
   logic [PW-1:0]  ay_ff, ay_in;
   logic [TW-1:0]  st_ff, st_in;
   logic [RW-1:0]  root_ff, root_in;
   logic [RW:0]    rem_ff, rem_in;
   logic [TW-1:0]  drem_ff, drem_in;

   logic [PW-1:0]  ax, ay;
   logic [MWE-1:0] acc_add;
   logic [RW+2:0]  rem_sh, trial;
   logic           sq_ge;
   logic [TW-1:0]  drem_sh, dvs;
   logic           dv_ge;
   logic           st_ok;
   logic           last;

   // magnitudes, step arithmetic
   always_comb begin
      ax      = sx[PW-1] ? (~sx + 1'b1) : sx;
      ay      = sy[PW-1] ? (~sy + 1'b1) : sy;
      st_ok   = !st[TW-1] && (st != '0);
      acc_add = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
      rem_sh  = {rem_ff, acc_ff[MWE-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      sq_ge   = rem_sh >= trial;
      drem_sh = {drem_ff[TW-2:0], root_ff[RW-1]};
      dvs     = {1'b0, st_ff[TW-2:0]};
      dv_ge   = drem_sh >= dvs;
      last    = cnt_ff == NW'(1);
   end

   // sequencer: squares, scale, root, divide
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      ay_in     = ay_ff;
      st_in     = st_ff;
      root_in   = root_ff;
      rem_in    = rem_ff;
      drem_in   = drem_ff;
      if (start) begin
         st_in = st;
         if (!st_ok) begin
            root_in  = RW'(ospc_pkg::SPEED_MAX);
            phase_in = ospc_pkg::PH_DONE;
         end else begin
            mcand_in  = MWE'(ax);
            mplier_in = BW'(ax);
            ay_in     = ay;
            acc_in    = '0;
            cnt_in    = NW'(PW);
            phase_in  = ospc_pkg::PH_SQX;
         end
      end else begin
         case (phase_ff)
            ospc_pkg::PH_SQX, ospc_pkg::PH_SQY, ospc_pkg::PH_SCALE: begin
               acc_in    = acc_add;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
               cnt_in    = cnt_ff - 1'b1;
               if (last) begin
                  case (phase_ff)
                     ospc_pkg::PH_SQX: begin
                        mcand_in  = MWE'(ay_ff);
                        mplier_in = BW'(ay_ff);
                        cnt_in    = NW'(PW);
                        phase_in  = ospc_pkg::PH_SQY;
                     end
                     ospc_pkg::PH_SQY: begin
                        mcand_in  = acc_add;
                        acc_in    = '0;
                        mplier_in = BW'(ospc_pkg::TIME_SCALE_SQ);
                        cnt_in    = NW'(SW);
                        phase_in  = ospc_pkg::PH_SCALE;
                     end
                     default: begin
                        rem_in   = '0;
                        root_in  = '0;
                        cnt_in   = NW'(RW);
                        phase_in = ospc_pkg::PH_SQRT;
                     end
                  endcase
               end
            end
            ospc_pkg::PH_SQRT: begin
               rem_in  = (RW+1)'(sq_ge ? (rem_sh - trial) : rem_sh);
               root_in = {root_ff[RW-2:0], sq_ge};
               acc_in  = acc_ff << 2;
               cnt_in  = cnt_ff - 1'b1;
               if (last) begin
                  drem_in  = '0;
                  cnt_in   = NW'(RW);
                  phase_in = ospc_pkg::PH_DIV;
               end
            end
            ospc_pkg::PH_DIV: begin
               drem_in = dv_ge ? (drem_sh - dvs) : drem_sh;
               root_in = {root_ff[RW-2:0], dv_ge};
               cnt_in  = cnt_ff - 1'b1;
               if (last) begin
                  phase_in = ospc_pkg::PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ospc_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      ay_ff     <= ay_in;
      st_ff     <= st_in;
      root_ff   <= root_in;
      rem_ff    <= rem_in;
      drem_ff   <= drem_in;
   end

   assign done  = phase_ff == ospc_pkg::PH_DONE;
   assign speed = root_ff;

endmodule

[src/ospc_dpath.sv]
module ospc_dpath #(
   parameter int TE = ospc_pkg::TABLE_ENTRIES_DEF,
   parameter int MS = ospc_pkg::MAX_SAMPLES_DEF,
   parameter int AC = ospc_pkg::AVERAGE_COUNT_DEF,
   parameter int SO = ospc_pkg::SKIP_OLDEST_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ospc_pkg::ctrl_cmd_type cmd,
   output ospc_pkg::dp_sts_type   sts,
   input  logic [31:0]           req_obstacle_id,
   input  logic [31:0]           req_frame_seq,
   input  logic signed [31:0]    req_pos_x,
   input  logic signed [31:0]    req_pos_y,
   input  logic [47:0]           req_time_us,
   input  logic [19:0]           req_reported_speed,
   input  logic [19:0]           cfg_threshold,
   input  logic [3:0]            cfg_window,
   input  logic [6:0]            cfg_capacity,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic                  rsp_needs_correction,
   output logic [19:0]           rsp_average_speed,
   output logic [1:0]            rsp_status
);

   localparam int IW   = $clog2(TE);
   localparam int OW   = $clog2(TE + 1);
   localparam int CW   = $clog2(MS + 1);
   localparam int HW   = $clog2(MS);
   localparam int SAW  = $clog2(TE * MS);
   localparam int PW   = 33 + $clog2(AC);
   localparam int TW   = 49 + $clog2(AC);
   localparam int RW   = (2 * PW + 1 + ospc_pkg::SCALE_W + 1) / 2;
   localparam int RC   = 2 * AC;
   localparam int RCW  = $clog2(RC + 1);
   localparam int MIN_NEED = ((ospc_pkg::MIN_RECORDS + SO) > (SO + AC)) ?
                             (ospc_pkg::MIN_RECORDS + SO) : (SO + AC);

   typedef struct packed {
      logic [31:0]   id;
      logic [31:0]   frame;
      logic [CW-1:0] count;
      logic [HW-1:0] head;
   } ent_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [47:0] t;
   } smp_type;

   // captured item
   logic [31:0] id_ff, frame_ff, x_ff, y_ff;
   logic [47:0] t_ff;
   logic [19:0] rep_ff;

   // table
   logic [TE-1:0] valid_ff;
   logic [OW-1:0] occ_ff;
   ent_type       ent_mem [TE];
   ent_type       ent_rd_ff;
   logic [OW-1:0] ix_ff;
   logic          stg_valid_ff;
   logic [IW-1:0] stg_idx_ff;
   logic [2:0]    limit_ff;
   logic          free_found_ff;
   logic [IW-1:0] free_idx_ff;
   logic [IW-1:0] found_idx_ff;
   logic [31:0]   fnd_frame_ff;
   logic [CW-1:0] fnd_count_ff;
   logic [HW-1:0] fnd_head_ff;

   // samples and sums
   smp_type        smp_mem [TE*MS];
   smp_type        smp_rd_ff;
   logic [RCW-1:0] ri_ff;
   logic           acc_valid_ff, acc_rear_ff, acc_last_ff;
   logic [PW-1:0]  sx_ff, sy_ff;
   logic [TW-1:0]  st_ff;

   // result
   logic        flag_ff;
   logic [19:0] avg_ff;
   logic        rsp_valid_ff, rsp_flag_ff;
   logic [19:0] rsp_avg_ff;
   logic [1:0]  rsp_status_ff;

   logic [6:0]    cap_eff;
   logic [15:0]   occ16, half16, tq16;
   logic          evict_needed;
   logic [2:0]    limit_in;
   logic          stg_vbit, match, stale, free_hit, sweep_last;
   logic [31:0]   age;
   logic [7:0]    cnt8, win8, wl8, pos8, li8, rpos8;
   logic          grow;
   logic [CW-1:0] app_cnt;
   logic [HW-1:0] app_head, wpos, rpos;
   logic [SAW-1:0] wr_addr, rd_addr;
   logic [RCW-1:0] rk;
   logic [PW-1:0]  xe, ye;
   logic [TW-1:0]  te;
   logic [RW-1:0]  speed, rep_ext, diff;
   logic           speed_done;

   // eviction fill levels
   always_comb begin
      cap_eff      = (cfg_capacity == '0) ? 7'd2 : cfg_capacity;
      occ16        = 16'(occ_ff);
      half16       = 16'(cap_eff >> 1);
      tq16         = 16'(({2'b00, cap_eff} + {1'b0, cap_eff, 1'b0}) >> 2);
      evict_needed = occ16 >= half16;
      limit_in     = (occ16 < tq16) ? ospc_pkg::STALE_LOW : ospc_pkg::STALE_HIGH;
   end

   // sweep stage: search or stale check on one entry
   always_comb begin
      stg_vbit   = valid_ff[stg_idx_ff];
      age        = frame_ff - ent_rd_ff.frame;
      match      = cmd.sweep && !cmd.evict_mode && stg_valid_ff && stg_vbit &&
                   (ent_rd_ff.id == id_ff);
      stale      = cmd.sweep && cmd.evict_mode && stg_valid_ff && stg_vbit &&
                   (age > 32'(limit_ff));
      free_hit   = cmd.sweep && stg_valid_ff && (!stg_vbit || stale) && !free_found_ff;
      sweep_last = cmd.sweep && stg_valid_ff && (stg_idx_ff == IW'(TE - 1));
   end

   // append position in the circular window
   always_comb begin
      wl8      = (cfg_window > 4'(ospc_pkg::MIN_RECORDS)) ? 8'(cfg_window) :
                 8'(ospc_pkg::MIN_RECORDS);
      win8     = (wl8 + 8'd1 > 8'(MS)) ? 8'(MS) : wl8 + 8'd1;
      cnt8     = 8'(fnd_count_ff);
      grow     = cnt8 < win8;
      app_cnt  = grow ? fnd_count_ff + 1'b1 : fnd_count_ff;
      app_head = grow ? fnd_head_ff :
                 ((fnd_head_ff == HW'(MS - 1)) ? '0 : fnd_head_ff + 1'b1);
      pos8     = 8'(fnd_head_ff) + cnt8;
      wpos     = HW'((pos8 >= 8'(MS)) ? pos8 - 8'(MS) : pos8);
      wr_addr  = cmd.insert ? SAW'(free_idx_ff) * SAW'(MS) :
                 SAW'(found_idx_ff) * SAW'(MS) + SAW'(wpos);
   end

   // sum read address: front group, then rear group, interleaved
   always_comb begin
      rk      = ri_ff >> 1;
      li8     = ri_ff[0] ? (8'(fnd_count_ff) - 8'd1 - 8'(rk)) : (8'(SO) + 8'(rk));
      rpos8   = 8'(fnd_head_ff) + li8;
      rpos    = HW'((rpos8 >= 8'(MS)) ? rpos8 - 8'(MS) : rpos8);
      rd_addr = SAW'(found_idx_ff) * SAW'(MS) + SAW'(rpos);
      xe      = {{(PW-32){smp_rd_ff.x[31]}}, smp_rd_ff.x};
      ye      = {{(PW-32){smp_rd_ff.y[31]}}, smp_rd_ff.y};
      te      = {{(TW-48){1'b0}}, smp_rd_ff.t};
   end

   // speed unit
   ospc_speed #(
      .PW(PW),
      .TW(TW),
      .RW(RW)
   ) u_speed (
      .clock (clock),
      .reset (reset),
      .start (cmd.speed_start),
      .sx    (sx_ff),
      .sy    (sy_ff),
      .st    (st_ff),
      .done  (speed_done),
      .speed (speed)
   );

   always_comb begin
      rep_ext = RW'(rep_ff);
      diff    = (speed > rep_ext) ? speed - rep_ext : rep_ext - speed;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         occ_ff        <= '0;
         ix_ff         <= '0;
         stg_valid_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         ri_ff         <= '0;
         acc_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.sweep_clear) begin
            ix_ff         <= '0;
            stg_valid_ff  <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (cmd.sweep) begin
            if (ix_ff < OW'(TE)) begin
               stg_valid_ff <= 1'b1;
               ix_ff        <= ix_ff + 1'b1;
            end else begin
               stg_valid_ff <= 1'b0;
            end
            if (free_hit) begin
               free_found_ff <= 1'b1;
            end
         end
         if (stale) begin
            valid_ff[stg_idx_ff] <= 1'b0;
            if (occ_ff != '0) begin
               occ_ff <= occ_ff - 1'b1;
            end
         end else if (cmd.insert) begin
            valid_ff[free_idx_ff] <= 1'b1;
            occ_ff                <= occ_ff + 1'b1;
         end
         if (cmd.append) begin
            ri_ff        <= '0;
            acc_valid_ff <= 1'b0;
         end else if (cmd.sum) begin
            if (ri_ff < RCW'(RC)) begin
               acc_valid_ff <= 1'b1;
               ri_ff        <= ri_ff + 1'b1;
            end else begin
               acc_valid_ff <= 1'b0;
            end
         end
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         id_ff    <= req_obstacle_id;
         frame_ff <= req_frame_seq;
         x_ff     <= req_pos_x;
         y_ff     <= req_pos_y;
         t_ff     <= req_time_us;
         rep_ff   <= req_reported_speed;
         flag_ff  <= 1'b0;
         avg_ff   <= '0;
      end else if (cmd.eval) begin
         flag_ff <= diff > RW'(cfg_threshold);
         avg_ff  <= (diff > RW'(cfg_threshold)) ?
                    ((speed > RW'(ospc_pkg::SPEED_MAX)) ? ospc_pkg::SPEED_MAX : speed[19:0]) :
                    '0;
      end
      if (cmd.sweep_clear) begin
         limit_ff <= limit_in;
      end
      if (cmd.sweep && ix_ff < OW'(TE)) begin
         stg_idx_ff <= ix_ff[IW-1:0];
      end
      if (free_hit) begin
         free_idx_ff <= stg_idx_ff;
      end
      if (match) begin
         found_idx_ff <= stg_idx_ff;
         fnd_frame_ff <= ent_rd_ff.frame;
         fnd_count_ff <= ent_rd_ff.count;
         fnd_head_ff  <= ent_rd_ff.head;
      end else if (cmd.append) begin
         fnd_count_ff <= app_cnt;
         fnd_head_ff  <= app_head;
      end
      if (cmd.sum && ri_ff < RCW'(RC)) begin
         acc_rear_ff <= ri_ff[0];
         acc_last_ff <= ri_ff == RCW'(RC - 1);
      end
      if (cmd.append) begin
         sx_ff <= '0;
         sy_ff <= '0;
         st_ff <= '0;
      end else if (acc_valid_ff) begin
         sx_ff <= acc_rear_ff ? sx_ff + xe : sx_ff - xe;
         sy_ff <= acc_rear_ff ? sy_ff + ye : sy_ff - ye;
         st_ff <= acc_rear_ff ? st_ff + te : st_ff - te;
      end
      if (cmd.publish) begin
         rsp_flag_ff   <= flag_ff;
         rsp_avg_ff    <= avg_ff;
         rsp_status_ff <= cmd.code;
      end
   end

   // entry table memory
   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         ent_mem[free_idx_ff] <= '{id: id_ff, frame: frame_ff, count: CW'(1), head: '0};
      end else if (cmd.append) begin
         ent_mem[found_idx_ff] <= '{id: id_ff, frame: frame_ff, count: app_cnt,
                                    head: app_head};
      end
      ent_rd_ff <= ent_mem[ix_ff[IW-1:0]];
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (cmd.insert || cmd.append) begin
         smp_mem[wr_addr] <= '{x: x_ff, y: y_ff, t: t_ff};
      end
      smp_rd_ff <= smp_mem[rd_addr];
   end

   always_comb begin
      sts.match        = match;
      sts.sweep_last   = sweep_last;
      sts.evict_needed = evict_needed;
      sts.free_found   = free_found_ff;
      sts.same_frame   = fnd_frame_ff == frame_ff;
      sts.enough       = 8'(app_cnt) >= 8'(MIN_NEED);
      sts.sum_last     = cmd.sum && acc_valid_ff && acc_last_ff;
      sts.speed_done   = speed_done;
      sts.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_needs_correction = rsp_flag_ff;
   assign rsp_average_speed    = rsp_avg_ff;
   assign rsp_status           = rsp_status_ff;

   // occupancy always matches the valid bits
   a_occ_count: assert property (@(posedge clock) disable iff (reset)
      32'($countones(valid_ff)) == 32'(occ_ff))
      else $error("occupied count differs from valid entries");

   // an insert only happens with a free entry in hand
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> free_found_ff)
      else $error("insert without free entry");

   // a published result is shown in the next cycle
   a_publish: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not presented");

endmodule

[src/ospc_ctrl.sv]
module ospc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ospc_pkg::dp_sts_type   sts,
   output ospc_pkg::ctrl_cmd_type cmd
);

   ospc_pkg::ctrl_state_type state_ff, state_in;
   logic [1:0] code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ospc_pkg::ST_IDLE;
         code_ff  <= ospc_pkg::STATUS_UPDATED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      cmd.code  = code_ff;
      req_stall = 1'b1;
      case (state_ff)
         ospc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture     = 1'b1;
               cmd.sweep_clear = 1'b1;
               state_in        = ospc_pkg::ST_SEARCH;
            end
         end
         ospc_pkg::ST_SEARCH: begin
            cmd.sweep = 1'b1;
            if (sts.match) begin
               state_in = ospc_pkg::ST_CHECK;
            end else if (sts.sweep_last) begin
               if (sts.evict_needed) begin
                  cmd.sweep_clear = 1'b1;
                  state_in        = ospc_pkg::ST_EVICT;
               end else begin
                  state_in = ospc_pkg::ST_INSERT;
               end
            end
         end
         ospc_pkg::ST_EVICT: begin
            cmd.sweep      = 1'b1;
            cmd.evict_mode = 1'b1;
            if (sts.sweep_last) begin
               state_in = ospc_pkg::ST_INSERT;
            end
         end
         ospc_pkg::ST_INSERT: begin
            if (sts.free_found) begin
               cmd.insert = 1'b1;
               code_in    = ospc_pkg::STATUS_INSERTED;
            end else begin
               code_in = ospc_pkg::STATUS_FULL;
            end
            state_in = ospc_pkg::ST_RESULT;
         end
         ospc_pkg::ST_CHECK: begin
            if (sts.same_frame) begin
               code_in  = ospc_pkg::STATUS_REPEAT;
               state_in = ospc_pkg::ST_RESULT;
            end else begin
               cmd.append = 1'b1;
               code_in    = ospc_pkg::STATUS_UPDATED;
               state_in   = sts.enough ? ospc_pkg::ST_SUM : ospc_pkg::ST_RESULT;
            end
         end
         ospc_pkg::ST_SUM: begin
            cmd.sum = 1'b1;
            if (sts.sum_last) begin
               state_in = ospc_pkg::ST_SPEED_GO;
            end
         end
         ospc_pkg::ST_SPEED_GO: begin
            cmd.speed_start = 1'b1;
            state_in        = ospc_pkg::ST_SPEED;
         end
         ospc_pkg::ST_SPEED: begin
            if (sts.speed_done) begin
               cmd.eval = 1'b1;
               state_in = ospc_pkg::ST_RESULT;
            end
         end
         ospc_pkg::ST_RESULT: begin
            if (sts.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ospc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ospc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[src/obstacle_speed_history_checker.sv]
// Obstacle speed history checker. Keeps a table of TABLE_ENTRIES tracked obstacles, each with
// a circular window of up to MAX_SAMPLES position/time samples, and returns one result item
// per report item. One item is worked on at a time: a report takes a search over the entry
// table (one entry a cycle), a stale-entry walk over the whole table when an unknown id meets
// a table holding at least half the configured capacity, then for a speed check 2*AVERAGE_COUNT
// sample reads and the serial speed unit: two shift-add squares, a scale, a one-bit-a-cycle
// square root and a restoring divide. Before its result is handed over, an item may also wait
// on rsp_stall. The result waits in an output register, so a new report is taken as soon as
// the previous one has been handed over to it.
module obstacle_speed_history_checker #(
   parameter int TABLE_ENTRIES = ospc_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_SAMPLES   = ospc_pkg::MAX_SAMPLES_DEF,
   parameter int AVERAGE_COUNT = ospc_pkg::AVERAGE_COUNT_DEF,
   parameter int SKIP_OLDEST   = ospc_pkg::SKIP_OLDEST_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_obstacle_id,
   input  logic [31:0]                     req_frame_seq,
   input  logic signed [31:0]              req_pos_x,
   input  logic signed [31:0]              req_pos_y,
   input  logic [47:0]                     req_time_us,
   input  logic [19:0]                     req_reported_speed,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_needs_correction,
   output logic [19:0]                     rsp_average_speed,
   output logic [1:0]                      rsp_status,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [ospc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   ospc_pkg::ctrl_cmd_type cmd;
   ospc_pkg::dp_sts_type   sts;

   logic [19:0] threshold_ff;
   logic [3:0]  window_ff;
   logic [6:0]  capacity_ff;
   logic [1:0]  reg_idx;
   logic        wr_en;

   // configuration registers
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ospc_pkg::THRESHOLD_RST;
         window_ff    <= ospc_pkg::WINDOW_RST;
         capacity_ff  <= ospc_pkg::CAPACITY_RST;
      end else if (wr_en) begin
         case (reg_idx)
            ospc_pkg::REG_THRESHOLD: threshold_ff <= csr_pwdata[19:0];
            ospc_pkg::REG_WINDOW:    window_ff    <= csr_pwdata[3:0];
            ospc_pkg::REG_CAPACITY:  capacity_ff  <= csr_pwdata[6:0];
            default: begin
               threshold_ff <= threshold_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         ospc_pkg::REG_THRESHOLD: csr_prdata = 32'(threshold_ff);
         ospc_pkg::REG_WINDOW:    csr_prdata = 32'(window_ff);
         ospc_pkg::REG_CAPACITY:  csr_prdata = 32'(capacity_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   ospc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ospc_dpath #(
      .TE(TABLE_ENTRIES),
      .MS(MAX_SAMPLES),
      .AC(AVERAGE_COUNT),
      .SO(SKIP_OLDEST)
   ) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_obstacle_id      (req_obstacle_id),
      .req_frame_seq        (req_frame_seq),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_time_us          (req_time_us),
      .req_reported_speed   (req_reported_speed),
      .cfg_threshold        (threshold_ff),
      .cfg_window           (window_ff),
      .cfg_capacity         (capacity_ff),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_needs_correction (rsp_needs_correction),
      .rsp_average_speed    (rsp_average_speed),
      .rsp_status           (rsp_status)
   );

endmodule
